// ===== rtl/core/twis_pkg.sv =====
// Shared types and constants for the time-window insertion search block.
package twis_pkg;

    localparam logic [1:0] ACT_TRAVEL = 2'd0;
    localparam logic [1:0] ACT_WINDOW = 2'd1;
    localparam logic [1:0] ACT_ROUTE  = 2'd2;
    localparam logic [1:0] ACT_SEARCH = 2'd3;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef logic [31:0] time_t;

    // Saturating unsigned add of two times
    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [32:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[32] ? TIME_MAX : s[31:0];
        end
    endfunction

endpackage

// ===== rtl/core/twis_eval.sv =====
// Leg evaluator: two saturating adds and a window check per leg, shared over all legs.
module twis_eval (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           leg_valid,
    input  twis_pkg::time_t leg_time,
    input  twis_pkg::time_t first_open,
    input  twis_pkg::time_t node_open,
    input  twis_pkg::time_t node_close,
    output twis_pkg::time_t cost,
    output logic           feasible
);
    import twis_pkg::*;

    time_t cost_reg, cost_next;
    time_t dep_reg, dep_next;
    logic  ok_reg, ok_next;
    time_t arr;

    // Accumulate cost and departure time one leg at a time
    always_comb
    begin
        cost_next = cost_reg;
        dep_next  = dep_reg;
        ok_next   = ok_reg;
        arr       = sat_add(dep_reg, leg_time);
        if (start)
        begin
            cost_next = '0;
            dep_next  = first_open;
            ok_next   = 1'b1;
        end
        else if (leg_valid)
        begin
            cost_next = sat_add(cost_reg, leg_time);
            if (node_close < arr)
                ok_next = 1'b0;
            dep_next = (arr > node_open) ? arr : node_open;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ok_reg <= 1'b0;
        else
            ok_reg <= ok_next;
    end

    always_ff @(posedge clk)
    begin
        cost_reg <= cost_next;
        dep_reg  <= dep_next;
    end

    assign cost     = cost_reg;
    assign feasible = ok_reg;

endmodule

// ===== rtl/core/time_window_insertion_search.sv =====
// Top level of the time-window insertion search block.
// Load items (travel time, window, route node) are accepted while in_ready is
// high. A search walks every candidate insertion; each candidate is evaluated
// leg by leg through the shared add/compare evaluator, paced by the
// travel-time memory read port (one registered read per cycle). With one
// inserted node up to 13 candidates, with two up to 91; then the best route
// is emitted one node per cycle while out_ready is high. in_ready is low
// while a search runs or results are being emitted.
module time_window_insertion_search #(
    parameter int MAX_NODES = 32,
    parameter int MAX_ROUTE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [4:0]  from_node,
    input  logic [4:0]  to_node,
    input  logic [31:0] time_a,
    input  logic [31:0] time_b,
    input  logic [3:0]  position,
    input  logic [3:0]  partial_length,
    input  logic [3:0]  begin_index,
    input  logic        insert_two,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [5:0] route_node,
    output logic [3:0]  route_position,
    output logic        found,
    output logic [31:0] best_time,
    output logic        last_node
);
    import twis_pkg::*;

    localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int RW = $clog2(MAX_ROUTE);
    localparam int CW = RW + 1;
    localparam logic [CW-1:0] PLEN_CAP = CW'(MAX_ROUTE - 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_LEG  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // Storage
    time_t          tt_mem [MAX_NODES*MAX_NODES];
    time_t          wo_mem [MAX_NODES];
    time_t          wc_mem [MAX_NODES];
    logic [NW-1:0]  pr_mem [MAX_ROUTE];

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  plen_reg, len_reg;
    logic [CW-1:0]  lo_reg, s0_reg, s1_reg, k_reg, ek_reg;
    logic           two_reg, have_reg;
    logic [NW-1:0]  n0_reg, n1_reg, prev_reg;
    time_t          best_cost_reg;
    time_t          tt_q, wo_q, wc_q;
    logic           leg_v_reg;

    // Candidate route node at position k
    function automatic logic [NW-1:0] cand(input logic [CW-1:0] k);
        logic [CW-1:0] idx;
        begin
            idx = k;
            if (!two_reg)
            begin
                if (k == s1_reg) return n1_reg;
                if (k > s1_reg) idx = k - CW'(1);
            end
            else
            begin
                if (k == s0_reg) return n0_reg;
                if (k == s1_reg + CW'(1)) return n1_reg;
                if (k > s1_reg + CW'(1)) idx = k - CW'(2);
                else if (k > s0_reg) idx = k - CW'(1);
            end
            cand = pr_mem[idx[RW-1:0]];
        end
    endfunction

    logic [NW-1:0] cur_node;
    assign cur_node = cand(k_reg);

    logic       ev_start;
    time_t      ev_cost;
    logic       ev_ok;

    twis_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ev_start),
        .leg_valid  (leg_v_reg),
        .leg_time   (tt_q),
        .first_open (wo_q),
        .node_open  (wo_q),
        .node_close (wc_q),
        .cost       (ev_cost),
        .feasible   (ev_ok)
    );

    logic accept_in;
    assign accept_in = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);

    logic [NW-1:0] fn, tn;
    assign fn = NW'(from_node);
    assign tn = NW'(to_node);

    // Memories: writes on loads, registered reads during the walk
    always_ff @(posedge clk)
    begin
        if (accept_in && action == ACT_TRAVEL)
            tt_mem[{fn, tn}] <= time_a;
        if (accept_in && action == ACT_WINDOW)
        begin
            wo_mem[fn] <= time_a;
            wc_mem[fn] <= time_b;
        end
        if (accept_in && action == ACT_ROUTE && int'(position) < MAX_ROUTE)
            pr_mem[position[RW-1:0]] <= fn;
        tt_q <= tt_mem[{prev_reg, cur_node}];
        wo_q <= wo_mem[cur_node];
        wc_q <= wc_mem[cur_node];
    end

    // Winning insertion positions are kept; the best route is rebuilt from
    // them while it is emitted.
    logic [CW-1:0] bs0_reg, bs1_reg;
    logic          take;
    assign take = (state_reg == S_DONE) && ev_ok && (!have_reg || ev_cost < best_cost_reg);

    logic [NW-1:0] emit_node;
    always_comb
    begin
        emit_node = pr_mem[ek_reg[RW-1:0]];
        if (!two_reg)
        begin
            if (ek_reg == bs1_reg) emit_node = n1_reg;
            else if (ek_reg > bs1_reg) emit_node = pr_mem[RW'(ek_reg - CW'(1))];
        end
        else
        begin
            if (ek_reg == bs0_reg) emit_node = n0_reg;
            else if (ek_reg == bs1_reg + CW'(1)) emit_node = n1_reg;
            else if (ek_reg > bs1_reg + CW'(1)) emit_node = pr_mem[RW'(ek_reg - CW'(2))];
            else if (ek_reg > bs0_reg) emit_node = pr_mem[RW'(ek_reg - CW'(1))];
        end
    end

    // Next-candidate indices
    logic [CW-1:0] ns0, ns1;
    logic          more;
    always_comb
    begin
        ns0 = s0_reg;
        ns1 = s1_reg + CW'(1);
        more = 1'b1;
        if (ns1 >= plen_reg)
        begin
            if (!two_reg)
                more = 1'b0;
            else
            begin
                ns0 = s0_reg + CW'(1);
                ns1 = (ns0 > lo_reg) ? ns0 : lo_reg;
                if (ns1 >= plen_reg) more = 1'b0;
            end
        end
    end

    // First window opening comes from a registered read, so it arrives in the cycle after the first node is addressed
    assign ev_start = (state_reg == S_LEG) && (k_reg == CW'(1));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept_in && action == ACT_SEARCH) state_next = S_NEXT;
            S_NEXT: state_next = more ? S_INIT : S_EMIT;
            S_INIT: state_next = S_LEG;
            S_LEG:  if (k_reg == len_reg) state_next = S_DONE;
            S_DONE: state_next = more ? S_INIT : S_EMIT;
            S_EMIT:
                if (out_ready && ek_reg + CW'(1) == len_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic [CW-1:0] pl_in, lo_in;
    always_comb
    begin
        pl_in = (CW'(partial_length) > PLEN_CAP) ? PLEN_CAP : CW'(partial_length);
        lo_in = (begin_index > 4'd1) ? CW'(begin_index) : CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            have_reg  <= 1'b0;
            leg_v_reg <= 1'b0;
            k_reg     <= '0;
            ek_reg    <= '0;
            best_cost_reg <= TIME_MAX;
            plen_reg  <= '0;
            len_reg   <= '0;
            lo_reg    <= '0;
            two_reg   <= 1'b0;
            n0_reg    <= '0;
            n1_reg    <= '0;
            prev_reg  <= '0;
            s0_reg    <= '0;
            s1_reg    <= '0;
            bs0_reg   <= '0;
            bs1_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            leg_v_reg <= (state_reg == S_LEG) && (k_reg != '0) && (k_reg != len_reg);
            case (state_reg)
                S_IDLE:
                    if (accept_in && action == ACT_SEARCH)
                    begin
                        plen_reg <= pl_in;
                        len_reg  <= pl_in + CW'(1) + CW'(insert_two);
                        lo_reg   <= lo_in;
                        two_reg  <= insert_two;
                        n0_reg   <= fn;
                        n1_reg   <= tn;
                        have_reg <= 1'b0;
                        best_cost_reg <= TIME_MAX;
                        ek_reg   <= '0;
                        // Seed just before the first candidate; S_NEXT advances s1 to lo
                        s0_reg   <= CW'(1);
                        s1_reg   <= lo_in - CW'(1);
                    end
                S_NEXT:
                begin
                    s0_reg <= ns0;
                    s1_reg <= ns1;
                    k_reg  <= '0;
                end
                S_INIT:
                begin
                    prev_reg <= cur_node;
                    k_reg    <= CW'(1);
                end
                S_LEG:
                begin
                    prev_reg <= cur_node;
                    if (k_reg != len_reg) k_reg <= k_reg + CW'(1);
                end
                S_DONE:
                begin
                    if (take)
                    begin
                        have_reg <= 1'b1;
                        best_cost_reg <= ev_cost;
                        bs0_reg <= s0_reg;
                        bs1_reg <= s1_reg;
                    end
                    s0_reg <= ns0;
                    s1_reg <= ns1;
                    k_reg  <= '0;
                end
                S_EMIT:
                    if (out_ready) ek_reg <= ek_reg + CW'(1);
                default: ;
            endcase
        end
    end

    assign out_valid      = (state_reg == S_EMIT);
    assign route_node     = have_reg ? 6'(emit_node) : -6'sd1;
    assign route_position = ek_reg[3:0];
    assign found          = have_reg;
    assign best_time      = best_cost_reg;
    assign last_node      = (ek_reg + CW'(1) == len_reg);

endmodule

// ===== rtl/core/twis_checker.sv =====
// Port-level checker for the insertion search block, bound to the top level.
module twis_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [31:0] best_time,
    input logic [3:0]  route_position,
    input logic        last_node
);
    // A result route is never emitted while inputs are taken
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready)) else $error("input taken during emit");
    // Positions step by one between items of a route
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_node |=> route_position == $past(route_position) + 4'd1)
        else $error("route position skipped");
    // No feasible route means saturated cost
    a_nf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> best_time == 32'hFFFF_FFFF) else $error("cost without find");
    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(best_time)) else $error("result dropped");
endmodule

bind time_window_insertion_search twis_checker u_twis_checker (.*);
